// ----- hw/rtl/lsdt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsdt_pkg
// Shared sizes and types for the LRU stack-distance tracker.
// ----------------------------------------------------------------------------
package lsdt_pkg;

	localparam int MAX_FRAMES  = 64;
	localparam int PAGE_BITS   = 32;

	localparam int PAGE_IN_W   = 32;  // page_number field
	localparam int CAP_W       = 7;   // capacity_in_use register
	localparam int DEPTH_W     = 6;   // stack_depth field
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	localparam int OCC_W       = $clog2(MAX_FRAMES + 1);
	localparam int CMP_W       = (OCC_W > CAP_W) ? OCC_W : CAP_W;
	localparam int IDX_W       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

	// match vector is reduced in groups of this many cells
	localparam int GRP_SIZE    = 8;
	localparam int NGRP        = (MAX_FRAMES + GRP_SIZE - 1) / GRP_SIZE;
	localparam int NPAD        = NGRP * GRP_SIZE;

	typedef logic [PAGE_BITS-1:0] page_t;

	typedef struct packed {
		logic shift;    // take the neighbour's page this cycle
	} cell_ctrl_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] depth;
	} loc_res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lsdt_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsdt_cell
// One slot of the recency stack: holds a page, compares it with the key and
// takes its younger neighbour's page when told to shift.
// ----------------------------------------------------------------------------
module lsdt_cell import lsdt_pkg::*; (
	input  wire logic       clk,
	input  wire cell_ctrl_t ctrl,
	input  wire page_t      prev_page,
	input  wire page_t      key,
	input  wire logic       valid,
	output page_t           page,
	output logic            match_s1
);

	page_t page_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			page_q <= prev_page;
		end
		match_s1 <= valid && (page_q == key);
	end

	assign page = page_q;

endmodule
`default_nettype wire

// ----- hw/rtl/lsdt_locate.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsdt_locate
// Finds the first matching cell from the MRU end: registered group ORs,
// prefix of "match above", then a registered one-hot to index encode.
// ----------------------------------------------------------------------------
module lsdt_locate import lsdt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  capture,
	input  wire logic [MAX_FRAMES-1:0] match_s1,
	output logic      [MAX_FRAMES-1:0] shift_en,
	output logic                       found,
	output loc_res_t                   res
);

	logic [NPAD-1:0]       match_pad;
	logic [NPAD-1:0]       match_s2;
	logic [NGRP-1:0]       grp_s2;
	logic [NPAD-1:0]       above;
	logic [MAX_FRAMES-1:0] first;
	logic [MAX_FRAMES-1:0] first_s3;
	logic                  hit_s3;
	logic [IDX_W-1:0]      depth_v;

	assign match_pad = NPAD'(match_s1);

	always_ff @(posedge clk) begin
		match_s2 <= match_pad;
		for (int g = 0; g < NGRP; g++) begin
			grp_s2[g] <= |match_pad[g*GRP_SIZE +: GRP_SIZE];
		end
	end

	// above[i]: some cell nearer the MRU end matched
	always_comb begin
		logic run;
		run   = 1'b0;
		above = '0;
		for (int g = 0; g < NGRP; g++) begin
			logic r;
			r = run;
			for (int j = 0; j < GRP_SIZE; j++) begin
				above[g*GRP_SIZE + j] = r;
				r = r | match_s2[g*GRP_SIZE + j];
			end
			run = run | grp_s2[g];
		end
	end

	assign shift_en = ~above[MAX_FRAMES-1:0];
	assign first    = match_s2[MAX_FRAMES-1:0] & ~above[MAX_FRAMES-1:0];
	assign found    = |grp_s2;

	// taken once per reference, in the update cycle; held while the result
	// waits so the compare of the updated row cannot leak in
	always_ff @(posedge clk) begin
		if (capture) begin
			first_s3 <= first;
			hit_s3   <= found;
		end
	end

	always_comb begin
		depth_v = '0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			if (first_s3[i]) begin
				depth_v = depth_v | IDX_W'(i);
			end
		end
	end

	assign res.hit   = hit_s3;
	assign res.depth = depth_v;

endmodule
`default_nettype wire

// ----- hw/rtl/lru_stack_distance_tracker_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lru_stack_distance_tracker_core
// Fully associative LRU recency stack reporting the stack distance of each
// page reference.
// ----------------------------------------------------------------------------
// One reference is handled at a time: a new reference is taken only once
// the last one's result has been loaded into the output register. The
// sequence is set by the walk through the cell row:
// compare in every cell, group reduction of the match vector, prefix and
// stack update, then the index encode into the output register. A result
// that waits on out_stall does not hold up the next reference, only the
// encode step of the one after it. Capacity is written through the cfg
// channel (always ready); the user must write it only while no reference is
// in flight, which the block itself does not enforce. Zero is taken as one
// and values above the cell count saturate to it. Lowering capacity below
// the current occupancy keeps the extra entries: each later miss evicts only the LRU page.
// ----------------------------------------------------------------------------
module lru_stack_distance_tracker_core import lsdt_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// reference input
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [PAGE_IN_W-1:0] page_number,
	// result output
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      hit,
	output logic [DEPTH_W-1:0]        stack_depth,
	// capacity write
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CAP_W-1:0]     cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CMP  = 5'b00010,
		ST_GRP  = 5'b00100,
		ST_UPD  = 5'b01000,
		ST_ENC  = 5'b10000
	} state_t;

	state_t                state_q;
	logic [CAP_W-1:0]      cap_q;
	logic [OCC_W-1:0]      occ_q;
	page_t                 req_q;
	logic [CMP_W-1:0]      cap_eff;

	logic                  out_valid_q;
	logic                  out_hit_q;
	logic [DEPTH_W-1:0]    out_depth_q;

	page_t                 cell_page [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] cell_valid;
	logic [MAX_FRAMES-1:0] match_s1;
	logic [MAX_FRAMES-1:0] shift_en;
	logic                  found;
	loc_res_t              res;

	logic                  in_xact;
	logic                  out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xact   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_ENC) && (!out_valid_q || !out_stall);

	// ---- capacity register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	always_comb begin
		cap_eff = CMP_W'(cap_q);
		if (cap_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(MAX_FRAMES)) begin
			cap_eff = CMP_W'(MAX_FRAMES);
		end
	end

	// ---- sequencer and occupancy ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xact) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: state_q <= ST_GRP;
				ST_GRP: state_q <= ST_UPD;
				ST_UPD: begin
					// a miss grows the stack until capacity, then evicts the LRU page
					if (!found && (CMP_W'(occ_q) < cap_eff)) begin
						occ_q <= occ_q + OCC_W'(1);
					end
					state_q <= ST_ENC;
				end
				ST_ENC: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// key for the compare; held for the whole transaction
	always_ff @(posedge clk) begin
		if (in_xact) begin
			req_q <= page_t'(page_number);
		end
	end

	// ---- cell row ----
	// slot 0 is MRU; on update, cells from the MRU end down to the hit (or
	// all of them on a miss) take their neighbour's page and slot 0 the key
	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		cell_ctrl_t ctrl;
		page_t      prev;

		assign ctrl.shift    = (state_q == ST_UPD) && shift_en[i];
		assign cell_valid[i] = occ_q > OCC_W'(i);

		if (i == 0) begin : g_head
			assign prev = req_q;
		end else begin : g_body
			assign prev = cell_page[i-1];
		end

		lsdt_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.prev_page (prev),
			.key       (req_q),
			.valid     (cell_valid[i]),
			.page      (cell_page[i]),
			.match_s1  (match_s1[i])
		);
	end

	lsdt_locate u_locate (
		.clk      (clk),
		.capture  (state_q == ST_UPD),
		.match_s1 (match_s1),
		.shift_en (shift_en),
		.found    (found),
		.res      (res)
	);

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_hit_q   <= res.hit;
			// depth is zero on a miss: the one-hot is empty then
			out_depth_q <= DEPTH_W'(res.depth);
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = out_hit_q;
	assign stack_depth = out_depth_q;

endmodule
`default_nettype wire

// ----- hw/rtl/lsdt_chk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsdt_chk
// Port-level checks for the LRU stack-distance tracker, bound to the core.
// ----------------------------------------------------------------------------
module lsdt_chk import lsdt_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic                 hit,
	input wire logic [DEPTH_W-1:0]   stack_depth
);

	// result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hit) && $stable(stack_depth))
		else $error("stalled result changed");

	// a miss always reports depth zero
	a_miss_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> stack_depth == '0)
		else $error("miss with non-zero depth");

	// one reference in flight: input stalls through the compare, group, update and encode states
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
		else $error("reference accepted while busy");

endmodule

bind lru_stack_distance_tracker_core lsdt_chk u_chk (.*);
`default_nettype wire
